// ===== hdl/lcg48_pkg.sv =====
package lcg48_pkg;

  // generator arithmetic
  localparam int unsigned STATE_W = 48;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned LOW_W   = 16;
  localparam int unsigned HALF_W  = 24;
  localparam int unsigned MUL_W   = 35;
  localparam int unsigned CNT_W   = 6;

  localparam logic [MUL_W-1:0]   LCG_MUL = 35'h5_DEEC_E66D;
  localparam logic [STATE_W-1:0] LCG_ADD = 48'd11;

  // most predictions per item, counts above this saturate
  localparam logic [CNT_W-1:0] MAX_PREDICT = 6'd63;

  // stream widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 88;

  // result kinds on out_tuser
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_PREDICT = 1'b1;

  // request to the step unit
  typedef struct packed {
    logic               start;
    logic [STATE_W-1:0] operand;
  } lcg48_mul_req_t;

  // answer of the step unit
  typedef struct packed {
    logic               done;
    logic [STATE_W-1:0] result;
  } lcg48_mul_rsp_t;

endpackage

// ===== hdl/lcg48_step_unit.sv =====
module lcg48_step_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lcg48_pkg::lcg48_mul_req_t req,
  output lcg48_pkg::lcg48_mul_rsp_t rsp
);
  import lcg48_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_SUM  = 4'b1000
  } mul_state_t;

  mul_state_t            state_r, state_nxt;
  logic [STATE_W-1:0]    op_r;
  logic [STATE_W-1:0]    plo_r;
  logic [HALF_W-1:0]     phi_r;
  logic [STATE_W-1:0]    res_r;
  logic                  done_r, done_nxt;

  // sequencer: low partial product, high partial product, final sum
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: if (req.start) state_nxt = M_LO;
      M_LO:   state_nxt = M_HI;
      M_HI:   state_nxt = M_SUM;
      M_SUM: begin
        state_nxt = M_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath: s * mul + add, mod 2^48, over the low, high and sum states
  always_ff @(posedge clk) begin
    if (state_r == M_IDLE && req.start) begin
      op_r <= req.operand;
    end
    if (state_r == M_LO) begin
      plo_r <= STATE_W'(op_r[HALF_W-1:0]) * STATE_W'(LCG_MUL);
    end
    if (state_r == M_HI) begin
      phi_r <= op_r[STATE_W-1:HALF_W] * LCG_MUL[HALF_W-1:0];
    end
    if (state_r == M_SUM) begin
      res_r <= plo_r + {phi_r, {HALF_W{1'b0}}} + LCG_ADD;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== hdl/lcg48_seed_recover_and_predict.sv =====
// 48-bit linear congruential generator: state recovery and prediction.
//
// Input channel (in_*): one item carries two consecutive generator outputs
// and a prediction count. in_tready is high only while the block is idle.
// Result channel (out_*): per item, one status result (out_tuser = 0) with
// the found flag and the recovered state, then, if a state was found, up to
// predict_count predicted outputs (out_tuser = 1). out_tlast marks the final
// result of an item.
// Flow: the first output goes once through the shared step unit; the search
// then tests one candidate per cycle with a single 48-bit adder, candidate k
// taking k as the low state bits, and stops at the first match or after
// SEARCH_CANDIDATES candidates, when the status result is registered. Each
// prediction runs the step unit again once the previous result is accepted.
// Reset (synchronous, active low) returns to idle with no result pending.
// A stalled receiver holds the current result steady and pauses the
// sequencer; nothing is lost or repeated.
module lcg48_seed_recover_and_predict #(
  parameter int unsigned SEARCH_CANDIDATES = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] first_output, [63:32] second_output, [69:64] predict_count
  input  logic [lcg48_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] seed_found, [48:1] recovered_state, [80:49] predicted_value
  output logic [lcg48_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] item_kind
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import lcg48_pkg::*;

  localparam int unsigned IDX_W =
    (SEARCH_CANDIDATES > 1) ? $clog2(SEARCH_CANDIDATES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEARCH_CANDIDATES - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEED   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_STATUS = 6'b001000,
    S_ADV    = 6'b010000,
    S_PRED   = 6'b100000
  } seq_state_t;

  seq_state_t           state_r, state_nxt;
  logic [OUT_W-1:0]     first_r;
  logic [OUT_W-1:0]     second_r;
  logic [CNT_W-1:0]     left_r;
  logic [IDX_W-1:0]     idx_r;
  logic [STATE_W-1:0]   acc_r;
  logic [STATE_W-1:0]   gen_r;
  logic                 found_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic                 out_found_r;
  logic [STATE_W-1:0]   out_state_r;
  logic [OUT_W-1:0]     out_value_r;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 out_fire;
  logic                 hit;
  logic [CNT_W-1:0]     cnt_in;
  logic [CNT_W-1:0]     cnt_sat;

  lcg48_mul_req_t       mul_req;
  lcg48_mul_rsp_t       mul_rsp;

  lcg48_step_unit u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign hit       = (acc_r[STATE_W-1:LOW_W] == second_r);
  assign cnt_in    = in_tdata[2*OUT_W +: CNT_W];
  assign cnt_sat   = (cnt_in > MAX_PREDICT) ? MAX_PREDICT : cnt_in;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    mul_req.start   = 1'b0;
    mul_req.operand = gen_r;
    unique case (state_r)
      S_IDLE: begin
        mul_req.operand = {in_tdata[OUT_W-1:0], {LOW_W{1'b0}}};
        if (in_fire) begin
          mul_req.start = 1'b1;
          state_nxt     = S_SEED;
        end
      end
      S_SEED: if (mul_rsp.done) state_nxt = S_SEARCH;
      S_SEARCH: begin
        if (hit || idx_r == LAST_IDX) state_nxt = S_STATUS;
      end
      S_STATUS: begin
        if (out_fire) begin
          if (found_r && left_r != '0) begin
            mul_req.start = 1'b1;
            state_nxt     = S_ADV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ADV: if (mul_rsp.done) state_nxt = S_PRED;
      S_PRED: begin
        if (out_fire) begin
          if (left_r != '0) begin
            mul_req.start = 1'b1;
            state_nxt     = S_ADV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SEARCH && (hit || idx_r == LAST_IDX)) begin
        out_valid_r <= 1'b1;
        found_r     <= hit;
      end else if (state_r == S_ADV && mul_rsp.done) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture, search walk and prediction datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      first_r  <= in_tdata[OUT_W-1:0];
      second_r <= in_tdata[OUT_W +: OUT_W];
      left_r   <= cnt_sat;
    end
    if (state_r == S_SEED && mul_rsp.done) begin
      acc_r <= mul_rsp.result;
      idx_r <= '0;
    end
    // next candidate's successor is the current one plus the multiplier
    if (state_r == S_SEARCH && !hit && idx_r != LAST_IDX) begin
      acc_r <= acc_r + STATE_W'(LCG_MUL);
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == S_SEARCH && (hit || idx_r == LAST_IDX)) begin
      gen_r       <= acc_r;
      out_kind_r  <= KIND_STATUS;
      out_found_r <= hit;
      out_state_r <= hit ? {first_r, LOW_W'(idx_r)} : '0;
      out_value_r <= '0;
      out_last_r  <= !hit || (left_r == '0);
    end
    if (state_r == S_ADV && mul_rsp.done) begin
      gen_r       <= mul_rsp.result;
      left_r      <= left_r - 1'b1;
      out_kind_r  <= KIND_PREDICT;
      out_found_r <= 1'b1;
      out_state_r <= '0;
      out_value_r <= mul_rsp.result[STATE_W-1:LOW_W];
      out_last_r  <= (left_r == CNT_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - 1 - STATE_W - OUT_W){1'b0}},
                       out_value_r, out_state_r, out_found_r};

  // checks
  a_ready_excl_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");

  a_step_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_SEED || state_r == S_ADV))
    else $error("step unit finished outside a waiting state");

  a_predict_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PREDICT) |-> found_r)
    else $error("prediction without a recovered state");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (idx_r <= LAST_IDX))
    else $error("search index past the last candidate");

  a_result_follows_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && state_nxt == S_STATUS) |=> out_tvalid)
    else $error("search ended without a status result");

endmodule
